FILE: design/ssm_pkg.sv
// Package for the sorted-set median block: widths, request and status codes,
// and the link record passed between neighbouring cells.
// No dependencies.
package ssm_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned MedianW     = 33;
  localparam int unsigned TotalW      = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_MEDIAN = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DUP   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    logic signed [ValueW-1:0] val;
    logic                     occ;
    logic                     gt;
  } cell_link_t;

endpackage

FILE: design/ssm_in_if.sv
// Request channel of the sorted-set median block.
// Depends on ssm_pkg.
interface ssm_in_if
  import ssm_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

FILE: design/ssm_out_if.sv
// Result channel of the sorted-set median block.
// Depends on ssm_pkg.
interface ssm_out_if
  import ssm_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [MedianW-1:0] median_doubled;
  logic [1:0]                status;
  logic [TotalW-1:0]         element_total;

  modport source (output valid, output median_doubled, output status,
                  output element_total, input ready);
  modport sink   (input valid, input median_doubled, input status,
                  input element_total, output ready);
endinterface

FILE: design/ssm_cell.sv
// One cell of the sorted chain: holds a single value and its occupied flag.
// Depends on ssm_pkg.
module ssm_cell
  import ssm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     commit_i,
  input  logic signed [ValueW-1:0] ins_val_i,
  input  cell_link_t               left_i,
  output cell_link_t               right_o,
  output logic                     eq_o,
  output logic signed [ValueW-1:0] val_o
);

  logic signed [ValueW-1:0] val_q, val_d;
  logic                     occ_q, occ_d;
  logic                     gt;

  // empty cells count as greater than any value
  assign gt = !occ_q || (val_q > ins_val_i);

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (commit_i) begin
      occ_d = occ_q | left_i.occ;
      if (left_i.gt) begin
        val_d = left_i.val;
      end else if (gt) begin
        val_d = ins_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign right_o.val = val_q;
  assign right_o.occ = occ_q;
  assign right_o.gt  = gt;
  assign eq_o        = occ_q && (val_q == ins_val_i);
  assign val_o       = val_q;

endmodule

FILE: design/sorted_set_median_top.sv
// Top level of the sorted-set median block: request register, sequencer,
// cell chain and result register.
// Depends on ssm_pkg, ssm_in_if, ssm_out_if and ssm_cell.
//
// Requests arrive on req_i (valid/ready); each carries a command and a value.
// An insert places the value into a chain of CAPACITY cells kept in ascending
// order; every cell compares the value and shifts from its neighbour in
// parallel. A median request picks the two middle cells (one cell twice for an
// odd count) and returns their sum.
// Exactly one result leaves on rsp_o per request.
// An insert or an empty median passes S_EXEC into the result register; a
// median over a non-empty set selects in S_EXEC, then adds in S_SUM. One
// request is in flight at a time, so a new request is taken once the previous
// one has reached the result register. The result register holds while the
// receiver stalls; a new request may be accepted meanwhile, and it waits in
// S_EXEC, or a non-empty median in S_SUM, until the slot frees.
// Reset empties the set and drops any request and result in flight.
module sorted_set_median_top
  import ssm_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssm_in_if.sink            req_i,
  ssm_out_if.source         rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SUM  = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic                      cmd_q;
  logic signed [ValueW-1:0]  val_q;
  logic [CntW-1:0]           count_q, count_d;
  logic signed [ValueW-1:0]  lo_q, hi_q;
  logic                      out_valid_q, out_valid_d;
  logic signed [MedianW-1:0] out_med_q, out_med_d;
  logic [1:0]                out_stat_q, out_stat_d;
  logic [TotalW-1:0]         out_tot_q, out_tot_d;
  logic                      load_out, load_mid, commit, out_free;

  cell_link_t                link [CAPACITY+1];
  logic [CAPACITY-1:0]       eq;
  logic signed [ValueW-1:0]  cell_val [CAPACITY];
  logic                      dup, full;
  logic [CntW-1:0]           cnt_m1;
  logic [IdxW-1:0]           idx_lo, idx_hi;
  logic signed [ValueW-1:0]  sel_lo, sel_hi;
  logic [31:0]               cnt_ext;

  assign link[0].val = '0;
  assign link[0].occ = 1'b1;
  assign link[0].gt  = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ssm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .commit_i (commit),
      .ins_val_i(val_q),
      .left_i   (link[g]),
      .right_o  (link[g+1]),
      .eq_o     (eq[g]),
      .val_o    (cell_val[g])
    );
  end

  assign dup    = |eq;
  assign full   = (count_q == CntW'(CAPACITY));
  assign cnt_m1 = count_q - CntW'(1);
  assign idx_lo = IdxW'(cnt_m1 >> 1);
  assign idx_hi = IdxW'(count_q >> 1);

  always_comb begin
    sel_lo = '0;
    sel_hi = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (idx_lo == IdxW'(i)) begin
        sel_lo = sel_lo | cell_val[i];
      end
      if (idx_hi == IdxW'(i)) begin
        sel_hi = sel_hi | cell_val[i];
      end
    end
  end

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    commit     = 1'b0;
    load_out   = 1'b0;
    load_mid   = 1'b0;
    out_med_d  = '0;
    out_stat_d = STAT_OK;
    count_d    = count_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q == CMD_INSERT) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = S_IDLE;
            if (dup) begin
              out_stat_d = STAT_DUP;
            end else if (full) begin
              out_stat_d = STAT_FULL;
            end else begin
              commit  = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end
        end else if (count_q == '0) begin
          if (out_free) begin
            load_out   = 1'b1;
            out_stat_d = STAT_EMPTY;
            state_d    = S_IDLE;
          end
        end else begin
          load_mid = 1'b1;
          state_d  = S_SUM;
        end
      end
      S_SUM: begin
        out_med_d = MedianW'(lo_q) + MedianW'(hi_q);
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cnt_ext     = 32'(count_d);
  assign out_tot_d   = cnt_ext[TotalW-1:0];
  assign out_valid_d = load_out || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q <= req_i.command;
      val_q <= req_i.value;
    end
    if (load_mid) begin
      lo_q <= sel_lo;
      hi_q <= sel_hi;
    end
    if (load_out) begin
      out_med_q  <= out_med_d;
      out_stat_q <= out_stat_d;
      out_tot_q  <= out_tot_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.median_doubled = out_med_q;
  assign rsp_o.status         = out_stat_q;
  assign rsp_o.element_total  = out_tot_q;

endmodule

FILE: test/sorted_set_median_top_tb.sv
// Testbench for sorted_set_median_top: drives insert and median requests with
// random gaps and stalls, and checks every result against a sorted-set model.
// Depends on ssm_pkg, ssm_in_if, ssm_out_if and the block itself.
`timescale 1ns / 100ps

module sorted_set_median_top_tb;
  import ssm_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandItems  = 2000;
  localparam int unsigned PrintLimit = 50;

  typedef struct packed {
    logic signed [MedianW-1:0] median;
    logic [1:0]                status;
    logic [TotalW-1:0]         total;
  } median_result_t;

  class median_scoreboard;
    logic signed [ValueW-1:0] held[$];
    median_result_t           due[$];
    int unsigned              capacity;
    int unsigned              errors;

    function new(int unsigned cap);
      capacity = cap;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function logic signed [MedianW-1:0] doubled_median();
      int unsigned n;
      longint      s;
      n = held.size();
      if (n[0]) s = 2 * longint'(held[(n - 1) / 2]);
      else s = longint'(held[n / 2 - 1]) + longint'(held[n / 2]);
      return s[MedianW-1:0];
    endfunction

    function void note_request(logic cmd, logic signed [ValueW-1:0] val);
      median_result_t r;
      int unsigned    pos;
      r = '0;
      if (cmd == CMD_INSERT) begin
        pos = 0;
        while (pos < held.size() && held[pos] < val) pos++;
        if (pos < held.size() && held[pos] == val) begin
          r.status = STAT_DUP;
        end else if (held.size() >= capacity) begin
          r.status = STAT_FULL;
        end else begin
          held.insert(pos, val);
          r.status = STAT_OK;
        end
      end else if (held.size() == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.median = doubled_median();
        r.status = STAT_OK;
      end
      r.total = TotalW'(held.size());
      due.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      if (errors < PrintLimit)
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(median_result_t got);
      median_result_t want;
      if (due.size() == 0) begin
        report("unexpected result, status", got.status, -1);
      end else begin
        want = due.pop_front();
        if (got.median !== want.median) report("median_doubled", got.median, want.median);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.total !== want.total) report("element_total", got.total, want.total);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  ssm_in_if  req_if ();
  ssm_out_if rsp_if ();

  sorted_set_median_top #(
    .CAPACITY (CapacityDef)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  median_scoreboard sb;
  int unsigned      cycle_count;
  int unsigned      stall_left;
  logic             steady;

  initial begin
    clk_i = 1'b0;
  end

  always #6ns clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ValueW-1:0] fresh_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 7) return ValueW'(int'($urandom_range(0, 32)) - 16);
    if (r < 8) return 32'h7FFF_FFFF - $urandom_range(0, 20);
    if (r < 9) return 32'h8000_0000 + $urandom_range(0, 20);
    return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
  endfunction

  // Hold valid until the request is taken; drop it only across a gap.
  task automatic send_request(logic cmd, logic signed [ValueW-1:0] val);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.value   <= val;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(cmd, val);
  endtask

  task automatic send_random();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send_request(CMD_MEDIAN, $urandom);
    end else if (sb.held.size() != 0 && r < 94) begin
      send_request(CMD_INSERT, sb.held[$urandom_range(0, sb.held.size() - 1)]);
    end else begin
      send_request(CMD_INSERT, fresh_value());
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sorted_set_median_top_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_result({rsp_if.median_doubled, rsp_if.status, rsp_if.element_total});
    if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= 1'b0;
      stall_left   <= pick_gap();
    end
  end

  initial begin
    sb             = new(CapacityDef);
    cycle_count    = 0;
    stall_left     = 0;
    steady         = 1'b0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.command = CMD_INSERT;
    req_if.value   = '0;
    rsp_if.ready   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_MEDIAN, 32'h0000_0000);
    send_request(CMD_MEDIAN, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'h7FFF_FFFF);
    send_request(CMD_MEDIAN, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h7FFF_FFFE);
    send_request(CMD_MEDIAN, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h7FFF_FFFF);
    send_request(CMD_INSERT, 32'h8000_0000);
    send_request(CMD_MEDIAN, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'h8000_0001);
    send_request(CMD_MEDIAN, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h8000_0000);
    send_request(CMD_INSERT, 32'h8000_0002);
    send_request(CMD_INSERT, 32'h8000_0003);
    send_request(CMD_MEDIAN, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h0000_0000);
    send_request(CMD_INSERT, 32'hFFFF_FFFF);
    send_request(CMD_MEDIAN, 32'h5555_5555);
    send_request(CMD_INSERT, 32'hAAAA_AAAA);
    send_request(CMD_INSERT, 32'h5555_5555);
    send_request(CMD_MEDIAN, 32'hAAAA_AAAA);
    send_request(CMD_INSERT, 32'h0000_0000);

    for (int unsigned i = 0; i < RandItems; i++) begin
      if (i % 250 == 0) steady <= ((i / 250) % 3 == 2);
      send_random();
    end
    // Fill the store if the random part left room, then probe it when full.
    while (sb.held.size() < CapacityDef) send_request(CMD_INSERT, fresh_value());
    send_request(CMD_INSERT, sb.held[0]);
    send_request(CMD_INSERT, fresh_value());
    send_request(CMD_MEDIAN, $urandom);
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sorted_set_median_top_tb: PASS");
    end else begin
      $display("sorted_set_median_top_tb: FAIL");
    end
    $finish;
  end

endmodule
